// ===== rtl/core/brr_pkg.sv =====
// Package for the bidi run reorder unit: sizes, sequencer states, datapath
// operations and the command and status structs between controller and datapath.
// Depends on nothing.
package brr_pkg;

    localparam int MAX_SPANS   = 64;
    localparam int POS_W       = $clog2(MAX_SPANS);
    localparam int CNT_W       = $clog2(MAX_SPANS + 1);
    localparam int LEVEL_W     = 7;
    localparam int INDEX_W     = 16;
    localparam int ENTRY_W     = LEVEL_W + POS_W;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [4:0] {
        S_LOAD,
        S_FIRST,
        S_START,
        S_READ_NEXT,
        S_EVAL,
        S_BACK,
        S_BACK_CHK,
        S_DROP,
        S_REV,
        S_SWAP_LO,
        S_SWAP_HI,
        S_ADV,
        S_OUT_RD,
        S_OUT_FILL,
        S_OUT_SEND
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ_FIRST,
        OP_START_WALK,
        OP_READ_NEXT,
        OP_EVAL_NEXT,
        OP_BACK,
        OP_BACK_CHK,
        OP_DROP,
        OP_REV,
        OP_SWAP_LO,
        OP_SWAP_HI,
        OP_ADVANCE,
        OP_OUT_READ,
        OP_OUT_FILL,
        OP_OUT_SEND
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic fall;
        logic rs_zero;
        logic back_lt;
        logic rev_odd;
        logic prev_gt_next;
        logic rev_more;
        logic still_fall;
        logic walk_done;
        logic out_taken;
        logic out_last;
    } status_t;

endpackage

// ===== rtl/core/brr_ctrl.sv =====
// Sequencer of the bidi run reorder unit: load, level walk, reversal and output.
// Depends on brr_pkg; drives the datapath brr_datapath through cmd_t.
module brr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  brr_pkg::status_t status,
    output brr_pkg::cmd_t    cmd
);
    import brr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = status.count_zero ? S_OUT_RD : S_FIRST;
                end
            end
            S_FIRST:     state_next = S_START;
            S_START:     state_next = S_READ_NEXT;
            S_READ_NEXT: state_next = S_EVAL;
            S_EVAL:      state_next = status.fall ? S_BACK : S_ADV;
            S_BACK:      state_next = status.rs_zero ? S_DROP : S_BACK_CHK;
            S_BACK_CHK:  state_next = status.back_lt ? S_DROP : S_BACK;
            S_DROP:
            begin
                if (status.rev_odd)
                begin
                    state_next = S_REV;
                end
                else
                begin
                    state_next = status.prev_gt_next ? S_BACK : S_ADV;
                end
            end
            S_REV:
            begin
                if (status.rev_more)
                begin
                    state_next = S_SWAP_LO;
                end
                else
                begin
                    state_next = status.still_fall ? S_BACK : S_ADV;
                end
            end
            S_SWAP_LO:   state_next = S_SWAP_HI;
            S_SWAP_HI:   state_next = S_REV;
            S_ADV:       state_next = status.walk_done ? S_OUT_RD : S_READ_NEXT;
            S_OUT_RD:    state_next = S_OUT_FILL;
            S_OUT_FILL:  state_next = S_OUT_SEND;
            S_OUT_SEND:
            begin
                if (status.out_taken)
                begin
                    state_next = status.out_last ? S_LOAD : S_OUT_RD;
                end
            end
            default:     state_next = S_LOAD;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_LOAD : OP_NONE;
            end
            S_FIRST:     cmd.op = OP_READ_FIRST;
            S_START:     cmd.op = OP_START_WALK;
            S_READ_NEXT: cmd.op = OP_READ_NEXT;
            S_EVAL:      cmd.op = OP_EVAL_NEXT;
            S_BACK:      cmd.op = OP_BACK;
            S_BACK_CHK:  cmd.op = OP_BACK_CHK;
            S_DROP:      cmd.op = OP_DROP;
            S_REV:       cmd.op = OP_REV;
            S_SWAP_LO:   cmd.op = OP_SWAP_LO;
            S_SWAP_HI:   cmd.op = OP_SWAP_HI;
            S_ADV:       cmd.op = OP_ADVANCE;
            S_OUT_RD:    cmd.op = OP_OUT_READ;
            S_OUT_FILL:  cmd.op = OP_OUT_FILL;
            S_OUT_SEND:  cmd.op = OP_OUT_SEND;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/brr_datapath.sv =====
// Datapath of the bidi run reorder unit: span memory of {level, order} entries,
// walk registers, level compares and the output register.
// Depends on brr_pkg; controlled by brr_ctrl.
module brr_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  brr_pkg::cmd_t                cmd,
    input  logic [brr_pkg::LEVEL_W-1:0]  in_level,
    input  logic [brr_pkg::INDEX_W-1:0]  in_base,
    input  logic                         out_ready,
    output brr_pkg::status_t             status,
    output logic [brr_pkg::INDEX_W-1:0]  out_data,
    output logic                         out_last,
    output logic                         out_valid
);
    import brr_pkg::*;

    // Each entry holds the level of the span at that visual position and its
    // local logical position, so both move together when a stretch is reversed.
    logic [ENTRY_W-1:0] entry_mem [MAX_SPANS];
    logic [ENTRY_W-1:0] rd_a_reg;
    logic [ENTRY_W-1:0] rd_b_reg;

    logic               wr_en;
    logic [POS_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_a_en;
    logic [POS_W-1:0]   rd_a_addr;
    logic               rd_b_en;
    logic [POS_W-1:0]   rd_b_addr;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [INDEX_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   rs_reg, rs_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [LEVEL_W-1:0] cur_reg, cur_next;
    logic [LEVEL_W-1:0] nxt_reg, nxt_next;
    logic [LEVEL_W-1:0] prev_reg, prev_next;
    logic [INDEX_W-1:0] out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic               out_valid_reg, out_valid_next;

    logic [LEVEL_W-1:0] rd_a_level;
    logic [POS_W-1:0]   rd_a_order;
    logic [CNT_W-1:0]   i_plus1;
    logic [CNT_W-1:0]   rs_minus1;
    logic [CNT_W-1:0]   hi_minus1;
    logic [CNT_W-1:0]   k_plus1;
    logic [LEVEL_W-1:0] next_val;
    logic [LEVEL_W-1:0] d1;
    logic [LEVEL_W-1:0] d2;
    logic [LEVEL_W-1:0] d_min;
    logic               has_next;

    assign rd_a_level = rd_a_reg[ENTRY_W-1 -: LEVEL_W];
    assign rd_a_order = rd_a_reg[POS_W-1:0];
    assign i_plus1    = i_reg + CNT_W'(1);
    assign rs_minus1  = rs_reg - CNT_W'(1);
    assign hi_minus1  = hi_reg - CNT_W'(1);
    assign k_plus1    = k_reg + CNT_W'(1);
    assign has_next   = (i_plus1 < count_reg);
    assign next_val   = has_next ? rd_a_level : '0;
    assign d1         = cur_reg - nxt_reg;
    assign d2         = cur_reg - prev_reg;
    assign d_min      = (d1 < d2) ? d1 : d2;

    assign status.count_zero   = (count_reg == '0);
    assign status.fall         = (cur_reg > next_val);
    assign status.rs_zero      = (rs_reg == '0);
    assign status.back_lt      = (rd_a_level < cur_reg);
    assign status.rev_odd      = d_min[0];
    assign status.prev_gt_next = (prev_reg > nxt_reg);
    assign status.rev_more     = ((lo_reg + CNT_W'(1)) < hi_reg);
    assign status.still_fall   = (cur_reg > nxt_reg);
    assign status.walk_done    = (i_plus1 == count_reg);
    assign status.out_taken    = out_valid_reg && out_ready;
    assign status.out_last     = out_last_reg;

    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_a_en        = 1'b0;
        rd_a_addr      = '0;
        rd_b_en        = 1'b0;
        rd_b_addr      = '0;
        count_next     = count_reg;
        base_next      = base_reg;
        i_next         = i_reg;
        rs_next        = rs_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        prev_next      = prev_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                k_next = '0;
                if (count_reg == '0)
                begin
                    base_next = in_base;
                end
                if (count_reg < CNT_W'(MAX_SPANS))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[POS_W-1:0];
                    wr_data    = {in_level, count_reg[POS_W-1:0]};
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_READ_FIRST:
            begin
                rd_a_en = 1'b1;
            end
            OP_START_WALK:
            begin
                cur_next = rd_a_level;
                i_next   = '0;
                rs_next  = '0;
            end
            OP_READ_NEXT:
            begin
                rd_a_en   = 1'b1;
                rd_a_addr = i_plus1[POS_W-1:0];
            end
            OP_EVAL_NEXT:
            begin
                nxt_next = next_val;
                if (cur_reg < next_val)
                begin
                    cur_next = next_val;
                    rs_next  = i_plus1;
                end
            end
            OP_BACK:
            begin
                if (rs_reg == '0)
                begin
                    prev_next = '0;
                end
                else
                begin
                    rs_next   = rs_minus1;
                    rd_a_en   = 1'b1;
                    rd_a_addr = rs_minus1[POS_W-1:0];
                end
            end
            OP_BACK_CHK:
            begin
                if (rd_a_level < cur_reg)
                begin
                    prev_next = rd_a_level;
                    rs_next   = rs_reg + CNT_W'(1);
                end
            end
            OP_DROP:
            begin
                cur_next = (prev_reg > nxt_reg) ? prev_reg : nxt_reg;
                lo_next  = rs_reg;
                hi_next  = i_plus1;
            end
            OP_REV:
            begin
                rd_a_en   = 1'b1;
                rd_a_addr = lo_reg[POS_W-1:0];
                rd_b_en   = 1'b1;
                rd_b_addr = hi_minus1[POS_W-1:0];
            end
            OP_SWAP_LO:
            begin
                wr_en   = 1'b1;
                wr_addr = lo_reg[POS_W-1:0];
                wr_data = rd_b_reg;
            end
            OP_SWAP_HI:
            begin
                wr_en   = 1'b1;
                wr_addr = hi_minus1[POS_W-1:0];
                wr_data = rd_a_reg;
                lo_next = lo_reg + CNT_W'(1);
                hi_next = hi_minus1;
            end
            OP_ADVANCE:
            begin
                i_next = i_plus1;
            end
            OP_OUT_READ:
            begin
                rd_a_en   = 1'b1;
                rd_a_addr = k_reg[POS_W-1:0];
            end
            OP_OUT_FILL:
            begin
                out_data_next  = base_reg + INDEX_W'(rd_a_order);
                out_last_next  = (k_plus1 == count_reg);
                out_valid_next = 1'b1;
            end
            OP_OUT_SEND:
            begin
                if (out_valid_reg && out_ready)
                begin
                    out_valid_next = 1'b0;
                    k_next         = k_plus1;
                    if (out_last_reg)
                    begin
                        count_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= entry_mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= entry_mem[rd_b_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        rs_reg       <= rs_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        k_reg        <= k_next;
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        prev_reg     <= prev_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== rtl/core/bidi_run_reorder_unit.sv =====
// Bidi run reorder unit: one line is in work at a time. Its spans load at one per
// cycle while the unit waits for input; the request marked last starts the reorder
// walk, or the output for a one-span line. The walk steps over spans, back over runs
// and swaps pairs, bound by the two-port span memory; results leave one at a time.
// Asynchronous active-low reset clears the control state; memory is not cleared.
module bidi_run_reorder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: level[6:0], base_index[22:7], zero fill [23].
    input  logic [brr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: span_index[15:0].
    output logic [brr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import brr_pkg::*;

    cmd_t    cmd;
    status_t status;

    brr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    brr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_level  (s_axis_tdata[LEVEL_W-1:0]),
        .in_base   (s_axis_tdata[LEVEL_W +: INDEX_W]),
        .out_ready (m_axis_tready),
        .status    (status),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_valid (m_axis_tvalid)
    );

endmodule
